[hw/rtl/multi_pattern_wildcard_matcher_unit_assert.svh]
// ----------------------------------------------------------------------------
// multi_pattern_wildcard_matcher_unit_assert.svh
// Assertion macros for the wildcard matcher. Every macro uses the clock clk
// and disables the check while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_PATTERN_WILDCARD_MATCHER_UNIT_ASSERT_SVH
`define MULTI_PATTERN_WILDCARD_MATCHER_UNIT_ASSERT_SVH

// Same-cycle implication: cons holds in the cycle in which ante holds.
`define MPWM_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: cons holds in the cycle after the one in which ante holds.
`define MPWM_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/mpwm_pkg.sv]
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared constants for the multi-pattern wildcard matcher.
// ----------------------------------------------------------------------------
package mpwm_pkg;

	// Default sizes
	localparam int NUM_PATTERNS_DEF    = 8;
	localparam int MAX_PATTERN_LEN_DEF = 16;

	// Field widths
	localparam int CHAR_W  = 8;
	localparam int SLOT_W  = 3;
	localparam int POS_W   = 4;
	localparam int MASK_W  = 8;

	// Item codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_WORD = 1'b1;

	// Wildcard characters
	localparam logic [CHAR_W-1:0] CH_ANY  = 8'd63;
	localparam logic [CHAR_W-1:0] CH_STAR = 8'd42;

endpackage

[hw/rtl/multi_pattern_wildcard_matcher_unit.sv]
// Flow: an accepted item is held in the input register; a word end's result is
//   loaded into the result register when that item leaves the input register.
// Throughput: one item per cycle unless a word end stalls on an untaken result;
//   the per-slot position-set update (advance plus star closure) is combinational.
// Reset: clears pattern lengths (all slots unused), word state and valids;
//   pattern characters are undefined until loaded.
// ----------------------------------------------------------------------------
// multi_pattern_wildcard_matcher_unit
// Matches streamed words against stored '?'/'*' patterns with one set of
// reachable pattern positions per slot, and reports a match mask per word.
// ----------------------------------------------------------------------------
`include "multi_pattern_wildcard_matcher_unit_assert.svh"

module multi_pattern_wildcard_matcher_unit #(
	parameter int NUM_PATTERNS    = mpwm_pkg::NUM_PATTERNS_DEF,
	parameter int MAX_PATTERN_LEN = mpwm_pkg::MAX_PATTERN_LEN_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        opcode,
	input  logic [mpwm_pkg::CHAR_W-1:0] character,
	input  logic [mpwm_pkg::SLOT_W-1:0] slot,
	input  logic [mpwm_pkg::POS_W-1:0]  position,
	input  logic                        is_last,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [mpwm_pkg::MASK_W-1:0] match_mask,
	output logic                        any_match
);
	import mpwm_pkg::*;

	localparam int LEN_W = $clog2(MAX_PATTERN_LEN + 1);
	localparam int PAD_W = (NUM_PATTERNS > MASK_W) ? NUM_PATTERNS : MASK_W;

	typedef logic [MAX_PATTERN_LEN:0]               pos_set_t;
	typedef logic [MAX_PATTERN_LEN-1:0][CHAR_W-1:0] pat_row_t;

	// Input register
	logic              valid_s1;
	logic              opcode_s1;
	logic [CHAR_W-1:0] character_s1;
	logic [SLOT_W-1:0] slot_s1;
	logic [POS_W-1:0]  position_s1;
	logic              is_last_s1;

	// Pattern and word state
	pat_row_t          chars_q  [NUM_PATTERNS];
	logic [LEN_W-1:0]  len_q    [NUM_PATTERNS];
	pos_set_t          active_q [NUM_PATTERNS];
	logic              in_word_q;

	// Result register
	logic              out_valid_q;
	logic [MASK_W-1:0] match_mask_q;
	logic              any_match_q;

	// Stage control
	logic              emit_s1;
	logic              adv_s1;
	logic              load_ok_s1;
	pos_set_t          next_set [NUM_PATTERNS];
	logic [NUM_PATTERNS-1:0] hit_mask;
	logic [PAD_W-1:0]  hit_pad;

	// Propagate reachability across '*' positions below the pattern length
	function automatic pos_set_t star_close(input pos_set_t v, input pat_row_t row,
			input logic [LEN_W-1:0] len);
		pos_set_t r;
		r = v;
		for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
			if (p < int'(len) && r[p] && row[p] == CH_STAR) begin
				r[p+1] = 1'b1;
			end
		end
		return r;
	endfunction

	// Step the position set over one word byte
	function automatic pos_set_t step_set(input pos_set_t cur, input pat_row_t row,
			input logic [LEN_W-1:0] len, input logic [CHAR_W-1:0] b);
		pos_set_t nxt;
		nxt = '0;
		for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
			if (p < int'(len) && cur[p]) begin
				if (row[p] == CH_STAR) begin
					nxt[p] = 1'b1;
				end
				if (row[p] == CH_ANY || row[p] == b) begin
					nxt[p+1] = 1'b1;
				end
			end
		end
		return star_close(nxt, row, len);
	endfunction

	// Handshake: hold the input stage only while its result cannot be placed
	assign emit_s1    = (opcode_s1 == OP_WORD) && is_last_s1;
	assign adv_s1     = valid_s1 && (!emit_s1 || !out_valid_q || out_ready);
	assign in_ready   = !valid_s1 || adv_s1;
	assign load_ok_s1 = (32'(slot_s1) < NUM_PATTERNS) && (32'(position_s1) < MAX_PATTERN_LEN);

	// Compute next position sets and whole-word hits for every slot
	always_comb begin
		pos_set_t base;
		for (int s = 0; s < NUM_PATTERNS; s++) begin
			base = in_word_q ? active_q[s]
				: star_close(pos_set_t'(1), chars_q[s], len_q[s]);
			next_set[s] = step_set(base, chars_q[s], len_q[s], character_s1);
			hit_mask[s] = (len_q[s] != '0) && next_set[s][len_q[s]];
		end
	end

	assign hit_pad = PAD_W'(hit_mask);

	// Capture the input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			opcode_s1    <= opcode;
			character_s1 <= character;
			slot_s1      <= slot;
			position_s1  <= position;
			is_last_s1   <= is_last;
		end
	end

	// Write pattern characters at the decoded slot and position
	always_ff @(posedge clk) begin
		for (int s = 0; s < NUM_PATTERNS; s++) begin
			for (int p = 0; p < MAX_PATTERN_LEN; p++) begin
				if (adv_s1 && opcode_s1 == OP_LOAD && load_ok_s1
						&& 32'(slot_s1) == s && 32'(position_s1) == p) begin
					chars_q[s][p] <= character_s1;
				end
			end
		end
	end

	// Update lengths, position sets and word state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_PATTERNS; s++) begin
				len_q[s]    <= '0;
				active_q[s] <= pos_set_t'(1);
			end
			in_word_q <= 1'b0;
		end else if (adv_s1) begin
			if (opcode_s1 == OP_LOAD) begin
				for (int s = 0; s < NUM_PATTERNS; s++) begin
					if (load_ok_s1 && is_last_s1 && 32'(slot_s1) == s) begin
						len_q[s] <= LEN_W'(32'(position_s1) + 32'd1);
					end
				end
			end else begin
				for (int s = 0; s < NUM_PATTERNS; s++) begin
					active_q[s] <= next_set[s];
				end
				in_word_q <= !is_last_s1;
			end
		end
	end

	// Result register: set on a word end, drop after the output transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && emit_s1) begin
			match_mask_q <= hit_pad[MASK_W-1:0];
			any_match_q  <= |hit_mask;
		end
	end

	assign out_valid  = out_valid_q;
	assign match_mask = match_mask_q;
	assign any_match  = any_match_q;

	// Checks
	`MPWM_ASSERT_IMP(a_mask_implies_any, out_valid_q && match_mask_q != '0, any_match_q, "match_mask set without any_match")
	`MPWM_ASSERT_IMP(a_stall_blocks_input, valid_s1 && emit_s1 && out_valid_q && !out_ready, !in_ready, "input taken while result is blocked")
	`MPWM_ASSERT_IMP(a_result_from_word_end, $rose(out_valid_q), $past(adv_s1 && emit_s1), "result without a word end")
	`MPWM_ASSERT_NXT(a_word_end_clears, adv_s1 && emit_s1, !in_word_q, "word state not cleared after word end")

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-pattern wildcard matcher. Pattern loads
// and word bytes stream in under bursty valid/ready traffic. A bit-parallel
// position-set tracker predicts the mask reported at each word end, and the
// output monitor compares every result transfer against it.
// ----------------------------------------------------------------------------
module tb;
	import mpwm_pkg::*;

	localparam int NSLOT      = NUM_PATTERNS_DEF;
	localparam int PLEN       = MAX_PATTERN_LEN_DEF;
	localparam int LEN_W      = $clog2(PLEN + 1);
	localparam int IDLE_LIMIT = 4000;
	localparam int LONG_HOLD  = 400;

	typedef struct packed {
		logic              opcode;
		logic [CHAR_W-1:0] character;
		logic [SLOT_W-1:0] slot;
		logic [POS_W-1:0]  position;
		logic              is_last;
	} mpwm_item_t;

	typedef struct packed {
		logic [MASK_W-1:0] match_mask;
		logic              any_match;
	} word_result_t;

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              in_valid   = 1'b0;
	logic              in_ready;
	logic              opcode     = OP_LOAD;
	logic [CHAR_W-1:0] character  = '0;
	logic [SLOT_W-1:0] slot       = '0;
	logic [POS_W-1:0]  position   = '0;
	logic              is_last    = 1'b0;
	logic              out_valid;
	logic              out_ready  = 1'b0;
	logic [MASK_W-1:0] match_mask;
	logic              any_match;

	// Stimulus queue and the generator's view of the loaded patterns
	mpwm_item_t        item_q[$];
	logic [CHAR_W-1:0] gen_pat [NSLOT][PLEN];
	int                gen_len [NSLOT];
	logic [PLEN-1:0]   gen_written [NSLOT];
	int                total_items = 0;

	// Matcher state as tracked by the bench
	logic [CHAR_W-1:0] pat_chars_m [NSLOT][PLEN];
	logic [LEN_W-1:0]  pat_len_m [NSLOT];
	logic [PLEN:0]     reach_m [NSLOT];
	logic              word_open = 1'b0;
	word_result_t      expected_results[$];

	int           accepted_count = 0;
	int           words_checked  = 0;
	int           fail_count     = 0;
	int           idle_cycles    = 0;
	int           burst_left     = 0;
	int           gap_left       = 0;
	int           hold_left      = 0;
	int           rx_cyc         = 0;
	bit           held_once      = 1'b0;
	mpwm_item_t   nxt_item;
	word_result_t want;

	multi_pattern_wildcard_matcher_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.character  (character),
		.slot       (slot),
		.position   (position),
		.is_last    (is_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.match_mask (match_mask),
		.any_match  (any_match)
	);

	always #6 clk = ~clk;

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	function automatic logic [CHAR_W-1:0] rand_char();
		case ($urandom_range(0, 9))
			0, 1, 2: return "a";
			3, 4:    return "b";
			5:       return "c";
			6:       return CH_ANY;
			7:       return CH_STAR;
			default: return CHAR_W'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic queue_load(int s, int p, logic [CHAR_W-1:0] c, logic last);
		mpwm_item_t it;
		it.opcode    = OP_LOAD;
		it.character = c;
		it.slot      = SLOT_W'(s);
		it.position  = POS_W'(p);
		it.is_last   = last;
		gen_pat[s][p]     = c;
		gen_written[s][p] = 1'b1;
		if (last)
			gen_len[s] = p + 1;
		item_q.insert(item_q.size(), it);
	endtask

	task automatic queue_byte(logic [CHAR_W-1:0] c, logic last);
		mpwm_item_t it;
		it.opcode    = OP_WORD;
		it.character = c;
		it.slot      = SLOT_W'($urandom_range(0, NSLOT - 1));
		it.position  = POS_W'($urandom_range(0, PLEN - 1));
		it.is_last   = last;
		item_q.insert(item_q.size(), it);
	endtask

	// Write a whole pattern in order, closing it with the length write
	task automatic load_pattern(int s, int n);
		for (int p = 0; p < n - 1; p++)
			queue_load(s, p, rand_char(), 1'b0);
		queue_load(s, n - 1, rand_char(), 1'b1);
	endtask

	// Build a word that mostly fits the pattern in slot s, then mutate it at times;
	// s < 0 or an unused slot gives a free random word
	task automatic emit_word(int s);
		logic [CHAR_W-1:0] w[$];
		int                k;
		if (s < 0 || gen_len[s] == 0) begin
			k = $urandom_range(1, 8);
			repeat (k) w.insert(w.size(), rand_char());
		end else begin
			for (int p = 0; p < gen_len[s]; p++) begin
				case (gen_pat[s][p])
					CH_STAR: repeat ($urandom_range(0, 3)) w.insert(w.size(), rand_char());
					CH_ANY:  w.insert(w.size(), rand_char());
					default: w.insert(w.size(), gen_pat[s][p]);
				endcase
			end
			if ($urandom_range(0, 3) == 0 && w.size() > 0)
				w[$urandom_range(0, w.size() - 1)] = CHAR_W'($urandom_range(0, 255));
			if ($urandom_range(0, 7) == 0)
				w.insert(w.size(), rand_char());
			if (w.size() == 0)
				w.insert(w.size(), rand_char());
		end
		for (int i = 0; i < w.size(); i++) begin
			// reload a slot in the middle of a word now and then
			if (i > 0 && $urandom_range(0, 39) == 0)
				load_pattern($urandom_range(0, NSLOT - 1), $urandom_range(1, 4));
			queue_byte(w[i], i == w.size() - 1);
		end
	endtask

	// ------------------------------------------------------------------------
	// Position-set tracker
	// ------------------------------------------------------------------------
	function automatic logic [PLEN:0] close_stars(int s, logic [PLEN:0] set);
		for (int p = 0; p < pat_len_m[s]; p++)
			if (set[p] && pat_chars_m[s][p] == CH_STAR)
				set[p + 1] = 1'b1;
		return set;
	endfunction

	task automatic step_matcher(mpwm_item_t it);
		word_result_t  res;
		logic [PLEN:0] nxt;
		if (it.opcode == OP_LOAD) begin
			pat_chars_m[it.slot][it.position] = it.character;
			if (it.is_last)
				pat_len_m[it.slot] = LEN_W'(it.position) + LEN_W'(1);
			return;
		end
		// open a new word at the start position of every slot
		if (!word_open) begin
			for (int s = 0; s < NSLOT; s++)
				reach_m[s] = close_stars(s, (PLEN + 1)'(1));
			word_open = 1'b1;
		end
		for (int s = 0; s < NSLOT; s++) begin
			nxt = '0;
			for (int p = 0; p < pat_len_m[s]; p++) begin
				if (reach_m[s][p]) begin
					if (pat_chars_m[s][p] == CH_STAR)
						nxt[p] = 1'b1;
					if (pat_chars_m[s][p] == CH_ANY || pat_chars_m[s][p] == it.character)
						nxt[p + 1] = 1'b1;
				end
			end
			reach_m[s] = close_stars(s, nxt);
		end
		if (it.is_last) begin
			res.match_mask = '0;
			for (int s = 0; s < NSLOT; s++)
				if (pat_len_m[s] != 0 && reach_m[s][pat_len_m[s]])
					res.match_mask[s] = 1'b1;
			res.any_match = |res.match_mask;
			expected_results.insert(expected_results.size(), res);
			word_open = 1'b0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Sequence: build stimulus, reset, wait for the last result
	// ------------------------------------------------------------------------
	initial begin
		int pick, s, p, n, m, target;
		bit last_ok;

		for (int i = 0; i < NSLOT; i++) begin
			gen_len[i]     = 0;
			gen_written[i] = '0;
			pat_len_m[i]   = '0;
			reach_m[i]     = (PLEN + 1)'(1);
			for (int j = 0; j < PLEN; j++) begin
				gen_pat[i][j]     = '0;
				pat_chars_m[i][j] = '0;
			end
		end

		// Directed: basic star pattern, then a word that nothing matches
		queue_load(0, 0, "a", 1'b0);
		queue_load(0, 1, CH_STAR, 1'b0);
		queue_load(0, 2, "b", 1'b1);
		queue_byte("z", 1'b1);
		queue_load(2, 0, CH_STAR, 1'b1);
		queue_load(1, 0, CH_ANY, 1'b0);
		queue_load(1, 1, CH_ANY, 1'b1);
		// top slot and position, zero byte, no length: slot stays unused
		queue_load(7, 15, 8'h00, 1'b0);
		// wildcard bytes inside a word are plain bytes
		queue_byte("a", 1'b0);
		queue_byte(CH_STAR, 1'b0);
		queue_byte("b", 1'b1);
		queue_byte(CH_ANY, 1'b1);
		// load in the middle of a word
		queue_byte("x", 1'b0);
		queue_load(3, 0, 8'hFF, 1'b1);
		queue_byte("y", 1'b1);
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h00, 1'b0);
		queue_byte("b", 1'b1);
		// rewrite a character and leave the length alone
		queue_load(0, 0, "c", 1'b0);
		queue_byte("c", 1'b0);
		queue_byte("b", 1'b1);

		// Random: mostly words shaped after stored patterns
		target = item_q.size() + 700;
		while (item_q.size() < target) begin
			pick = $urandom_range(0, 99);
			s    = $urandom_range(0, NSLOT - 1);
			if (pick < 12) begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, PLEN) : $urandom_range(1, 5);
				load_pattern(s, n);
			end else if (pick < 18) begin
				// stray character write; set the length only when all lower positions hold data
				p       = $urandom_range(0, PLEN - 1);
				m       = (1 << (p + 1)) - 1;
				last_ok = ((int'(gen_written[s]) | (1 << p)) & m) == m;
				queue_load(s, p, CHAR_W'($urandom_range(0, 255)),
					last_ok && $urandom_range(0, 1) == 1);
			end else if (pick < 24) begin
				emit_word(-1);
			end else begin
				emit_word(s);
			end
		end
		total_items = item_q.size();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_count != total_items) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Input driver: bursts of transfers separated by random gaps
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			opcode     <= OP_LOAD;
			character  <= '0;
			slot       <= '0;
			position   <= '0;
			is_last    <= 1'b0;
			burst_left = 0;
			gap_left   = 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (item_q.size() != 0) begin
				nxt_item = item_q.pop_front();
				opcode    <= nxt_item.opcode;
				character <= nxt_item.character;
				slot      <= nxt_item.slot;
				position  <= nxt_item.position;
				is_last   <= nxt_item.is_last;
				in_valid  <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 30);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver: one long hold after 15 checked words amid rotating stall patterns
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (!held_once && words_checked >= 15) begin
			held_once = 1'b1;
			hold_left = LONG_HOLD;
			out_ready <= 1'b0;
		end else begin
			rx_cyc++;
			case ((rx_cyc / 256) % 3)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ((rx_cyc % 7) < 3);
			endcase
		end
	end

	// Track every accepted input transfer
	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			step_matcher('{opcode, character, slot, position, is_last});
			accepted_count++;
		end
	end

	// Compare every result transfer with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			words_checked++;
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected, got match_mask %h any_match %b",
					$time, match_mask, any_match);
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				if (match_mask !== want.match_mask) begin
					$display("%0t: match_mask expected %h got %h",
						$time, want.match_mask, match_mask);
					fail_count++;
				end
				if (any_match !== want.any_match) begin
					$display("%0t: any_match expected %b got %b",
						$time, want.any_match, any_match);
					fail_count++;
				end
			end
		end
	end

	// Stop a run in which no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
				$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule
